/* rtl/tlpt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlpt_pkg
// shared codes, widths and controller/datapath interface types for the
// two-level page table engine
// ----------------------------------------------------------------------------
package tlpt_pkg;

	localparam int NUM_TABLES_DEF = 16;

	// address split of a 32-bit virtual address
	localparam int VA_W       = 32;
	localparam int PAGE_OFS_W = 12;
	localparam int TBL_IDX_W  = 10;
	localparam int DIR_IDX_W  = 10;
	localparam int VPN_W      = VA_W - PAGE_OFS_W;
	localparam int DIR_DEPTH  = 1 << DIR_IDX_W;
	localparam int TBL_DEPTH  = 1 << TBL_IDX_W;

	// stream widths
	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 56;
	localparam int ACT_W      = 2;
	localparam int STAT_W     = 2;

	localparam logic [ACT_W-1:0] ACT_MAP    = 2'd0;
	localparam logic [ACT_W-1:0] ACT_UNMAP  = 2'd1;
	localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOMAP = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

	// what the datapath loads into the output register
	typedef enum logic [2:0] {
		RES_DONE_INV,
		RES_NOMAP,
		RES_FULL,
		RES_LOOKUP,
		RES_ZERO
	} res_kind_t;

	typedef struct packed {
		logic      clr;
		logic      cap;
		logic      alloc;
		logic      tbl_wr;
		logic      tbl_rd;
		logic      res_load;
		res_kind_t res_kind;
	} dp_cmd_t;

	typedef struct packed {
		logic             clr_last;
		logic             dir_hit;
		logic             pool_full;
		logic             out_free;
		logic [ACT_W-1:0] act;
	} dp_stat_t;

endpackage
`default_nettype wire

/* rtl/tlpt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlpt_ctrl
// request sequencer: clearing pass, directory step, table read step
// ----------------------------------------------------------------------------
module tlpt_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              s_tvalid,
	output logic             s_tready,
	input  tlpt_pkg::dp_stat_t stat,
	output tlpt_pkg::dp_cmd_t  cmd
);
	import tlpt_pkg::*;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_DIR,
		S_TBL
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		cmd          = '0;
		cmd.res_kind = RES_ZERO;
		state_d      = state_q;
		s_tready     = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.cap = 1'b1;
					state_d = S_DIR;
				end
			end
			S_DIR: begin
				if (stat.out_free) begin
					state_d      = S_IDLE;
					cmd.res_load = 1'b1;
					case (stat.act)
						ACT_MAP: begin
							if (stat.dir_hit) begin
								cmd.tbl_wr   = 1'b1;
								cmd.res_kind = RES_DONE_INV;
							end else if (stat.pool_full) begin
								cmd.res_kind = RES_FULL;
							end else begin
								cmd.alloc    = 1'b1;
								cmd.tbl_wr   = 1'b1;
								cmd.res_kind = RES_DONE_INV;
							end
						end
						ACT_UNMAP: begin
							if (stat.dir_hit) begin
								cmd.tbl_wr   = 1'b1;
								cmd.res_kind = RES_DONE_INV;
							end else begin
								cmd.res_kind = RES_NOMAP;
							end
						end
						ACT_LOOKUP: begin
							if (stat.dir_hit) begin
								// result waits for the table read
								cmd.res_load = 1'b0;
								cmd.tbl_rd   = 1'b1;
								state_d      = S_TBL;
							end else begin
								cmd.res_kind = RES_NOMAP;
							end
						end
						default: begin
							cmd.res_kind = RES_ZERO;
						end
					endcase
				end
			end
			S_TBL: begin
				if (stat.out_free) begin
					cmd.res_load = 1'b1;
					cmd.res_kind = RES_LOOKUP;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/tlpt_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tlpt_dp
// directory and table memories, pool counter, request and result registers
// ----------------------------------------------------------------------------
module tlpt_dp #(
	parameter int NUM_TABLES = tlpt_pkg::NUM_TABLES_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  tlpt_pkg::dp_cmd_t                 cmd,
	output tlpt_pkg::dp_stat_t                stat,
	input  wire [tlpt_pkg::ACT_W-1:0]         s_act,
	input  wire [tlpt_pkg::IN_DATA_W-1:0]     s_data,
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [tlpt_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic [tlpt_pkg::STAT_W-1:0]       m_tuser
);
	import tlpt_pkg::*;

	// directory entry: 0 absent, k names pool table k-1
	localparam int DirW     = $clog2(NUM_TABLES + 1);
	localparam int PoolW    = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
	localparam int SlotW    = PoolW + TBL_IDX_W;
	localparam int TblWords = NUM_TABLES * TBL_DEPTH;
	localparam logic [SlotW-1:0] ClrLast = SlotW'(TblWords - 1);
	localparam logic [DirW-1:0]  PoolMax = DirW'(NUM_TABLES);

	logic [DirW-1:0]  dir_mem [DIR_DEPTH];
	logic [VA_W-1:0]  tbl_mem [TblWords];

	logic [ACT_W-1:0]  act_q;
	logic [VPN_W-1:0]  vpn_q;
	logic [VPN_W-1:0]  ppn_q;
	logic [PAGE_OFS_W-1:0] flags_q;
	logic [DirW-1:0]   dir_rd_q;
	logic [VA_W-1:0]   tbl_rd_q;
	logic [DirW-1:0]   next_free_q;
	logic [SlotW-1:0]  clr_cnt_q;

	logic [STAT_W-1:0] res_stat_q;
	logic [VA_W-1:0]   res_addr_q;
	logic              res_inv_q;
	logic [VPN_W-1:0]  res_page_q;

	logic [DIR_IDX_W-1:0] di_in;
	logic [DIR_IDX_W-1:0] di_q;
	logic [TBL_IDX_W-1:0] ti_q;
	logic [PoolW-1:0]     pool_idx;
	logic [SlotW-1:0]     slot;
	logic [VA_W-1:0]      wr_entry;
	logic                 tbl_nz;

	assign di_in = s_data[VA_W-1 -: DIR_IDX_W];
	assign di_q  = vpn_q[VPN_W-1 -: DIR_IDX_W];
	assign ti_q  = vpn_q[TBL_IDX_W-1:0];

	// a fresh table takes the next pool slot, else the one the directory names
	assign pool_idx = cmd.alloc ? PoolW'(next_free_q) : PoolW'(dir_rd_q - DirW'(1));
	assign slot     = {pool_idx, ti_q};
	assign wr_entry = (act_q == ACT_MAP) ? {ppn_q, flags_q} : '0;
	assign tbl_nz   = (tbl_rd_q != '0);

	assign stat.clr_last  = (clr_cnt_q == ClrLast);
	assign stat.dir_hit   = (dir_rd_q != '0);
	assign stat.pool_full = (next_free_q == PoolMax);
	assign stat.out_free  = !m_tvalid || m_tready;
	assign stat.act       = act_q;

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			act_q   <= s_act;
			vpn_q   <= s_data[VA_W-1:PAGE_OFS_W];
			ppn_q   <= s_data[2*VA_W-1:VA_W+PAGE_OFS_W];
			flags_q <= s_data[2*VA_W+PAGE_OFS_W-1:2*VA_W];
		end
	end

	// directory memory
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			dir_mem[clr_cnt_q[DIR_IDX_W-1:0]] <= '0;
		end else if (cmd.alloc) begin
			dir_mem[di_q] <= next_free_q + DirW'(1);
		end
		if (cmd.cap) begin
			dir_rd_q <= dir_mem[di_in];
		end
	end

	// second-level table memory
	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			tbl_mem[clr_cnt_q] <= '0;
		end else if (cmd.tbl_wr) begin
			tbl_mem[slot] <= wr_entry;
		end
		if (cmd.tbl_rd) begin
			tbl_rd_q <= tbl_mem[slot];
		end
	end

	// pool counter and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_free_q <= '0;
			clr_cnt_q   <= '0;
		end else begin
			if (cmd.alloc) begin
				next_free_q <= next_free_q + DirW'(1);
			end
			if (cmd.clr && !stat.clr_last) begin
				clr_cnt_q <= clr_cnt_q + SlotW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_stat_q <= ST_OK;
			res_addr_q <= '0;
			res_inv_q  <= 1'b0;
			res_page_q <= '0;
			case (cmd.res_kind)
				RES_DONE_INV: begin
					res_inv_q  <= 1'b1;
					res_page_q <= vpn_q;
				end
				RES_NOMAP: begin
					res_stat_q <= ST_NOMAP;
				end
				RES_FULL: begin
					res_stat_q <= ST_FULL;
				end
				RES_LOOKUP: begin
					if (tbl_nz) begin
						res_addr_q <= {tbl_rd_q[VA_W-1:PAGE_OFS_W], PAGE_OFS_W'(0)};
					end else begin
						res_stat_q <= ST_NOMAP;
					end
				end
				default: begin
					res_stat_q <= ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.res_load) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	assign m_tdata = {3'b000, res_page_q, res_inv_q, res_addr_q};
	assign m_tuser = res_stat_q;

endmodule
`default_nettype wire

/* rtl/two_level_page_table_engine.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_page_table_engine
// i386-style two-level page table: map, unmap and lookup of 4 KiB pages
// with second-level tables taken from a fixed pool
// ----------------------------------------------------------------------------
//
//  channel  dir  tdata (low bit up)                         tuser
//  s_*      in   virt_addr[31:0] phys_addr[31:0]            action[1:0]
//                entry_flags[11:0] 4'b0
//  m_*      out  mapped_addr[31:0] tlb_invalidate           status[1:0]
//                invalidate_page[19:0] 3'b0
//
//  map and unmap read the directory entry on accept, then write the table entry
//  through the single port of the table memory; lookup reads the directory
//  entry, reads the table entry through that port, then loads the read data
//  after reset a clearing pass zeroes both memories over NUM_TABLES*1024
//  table words (16384 at the default), with s_tready low throughout
//  one item is in work at a time; a result waiting in the output register
//  does not stop the next item from being accepted, but the sequencer holds
//  before its commit step until the output register is free
//
module two_level_page_table_engine #(
	parameter int NUM_TABLES = tlpt_pkg::NUM_TABLES_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// virt_addr, phys_addr, entry_flags, pad
	input  wire [tlpt_pkg::IN_DATA_W-1:0]    s_tdata,
	// action
	input  wire [tlpt_pkg::ACT_W-1:0]        s_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// mapped_addr, tlb_invalidate, invalidate_page, pad
	output logic [tlpt_pkg::OUT_DATA_W-1:0]  m_tdata,
	// status
	output logic [tlpt_pkg::STAT_W-1:0]      m_tuser
);
	import tlpt_pkg::*;

	// command and status between sequencer and datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	tlpt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// memories, pool counter and output register
	tlpt_dp #(
		.NUM_TABLES (NUM_TABLES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.s_act    (s_tuser),
		.s_data   (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire

/* bench/two_level_page_table_engine_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_level_page_table_engine_test
// self-checking bench for the page table engine: directed map, unmap and
// lookup cases, a reserved action, pool exhaustion, then random traffic on a
// few hot pages under changing sender and receiver idling, each result checked in order
// ----------------------------------------------------------------------------
module two_level_page_table_engine_test;

	import tlpt_pkg::*;

	localparam int          POOL_SIZE  = NUM_TABLES_DEF;
	localparam int unsigned CYCLE_CAP  = 1_000_000;
	localparam logic [ACT_W-1:0] ACT_RSVD   = 2'd3;
	localparam logic [31:0]      FRAME_MASK = 32'hFFFF_F000;

	// one result item as the bench sees it
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [31:0]       mapped_addr;
		logic              tlb_inv;
		logic [VPN_W-1:0]  inv_page;
	} page_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// virt_addr, phys_addr, entry_flags, pad
	logic [IN_DATA_W-1:0] s_tdata = '0;
	// action
	logic [ACT_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// mapped_addr, tlb_invalidate, invalidate_page, pad
	logic [OUT_DATA_W-1:0] m_tdata;
	// status
	logic [STAT_W-1:0] m_tuser;

	// shadow copy of the page tables
	int unsigned  page_dir [DIR_DEPTH];
	logic [31:0]  pte_store [POOL_SIZE*TBL_DEPTH];
	int unsigned  tables_used;
	logic [DIR_IDX_W-1:0] owned_dirs [$];

	page_result_t expected_results [$];
	bit           failed = 1'b0;
	int unsigned  cycle_count = 0;
	int unsigned  send_idle_pct = 27;
	int unsigned  recv_idle_pct = 82;

	two_level_page_table_engine #(.NUM_TABLES(POOL_SIZE)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// walk the shadow tables for one accepted item and update them
	function automatic page_result_t walk_page_tables(input logic [ACT_W-1:0] act,
			input logic [31:0] va, input logic [31:0] pa, input logic [11:0] flags);
		page_result_t res;
		int unsigned  dir_idx;
		int unsigned  tbl;
		int unsigned  slot;
		res     = '0;
		dir_idx = 32'(va[31:22]);
		tbl     = page_dir[dir_idx];
		slot    = 0;
		if (tbl != 0)
			slot = (tbl - 1) * TBL_DEPTH + va[21:12];
		case (act)
			ACT_MAP: begin
				// absent directory entry takes the next pool table, if any left
				if (tbl == 0 && tables_used < POOL_SIZE) begin
					tables_used++;
					tbl = tables_used;
					page_dir[dir_idx] = tbl;
					owned_dirs.push_back(va[31:22]);
					slot = (tbl - 1) * TBL_DEPTH + va[21:12];
				end
				if (tbl == 0) begin
					res.status = ST_FULL;
				end else begin
					pte_store[slot] = (pa & FRAME_MASK) | {20'd0, flags};
					res.tlb_inv  = 1'b1;
					res.inv_page = va[31:12];
				end
			end
			ACT_UNMAP: begin
				if (tbl == 0) begin
					res.status = ST_NOMAP;
				end else begin
					pte_store[slot] = '0;
					res.tlb_inv  = 1'b1;
					res.inv_page = va[31:12];
				end
			end
			ACT_LOOKUP: begin
				if (tbl == 0 || pte_store[slot] == '0)
					res.status = ST_NOMAP;
				else
					res.mapped_addr = pte_store[slot] & FRAME_MASK;
			end
			default: ; // reserved action: nothing changes, all fields zero
		endcase
		return res;
	endfunction

	// offer one request item, with a random gap first, and log what it should give
	task automatic send_request(input logic [ACT_W-1:0] act, input logic [31:0] va,
			input logic [31:0] pa, input logic [11:0] flags);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {4'b0, flags, pa, va};
		s_tuser  <= act;
		do
			@(posedge clk);
		while (!s_tready);
		expected_results.push_back(walk_page_tables(act, va, pa, flags));
	endtask

	// hold off the sender until every outstanding result is back
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (expected_results.size() != 0);
	endtask

	// mostly hot pages in tables that exist, now and then any address at all
	function automatic logic [31:0] pick_vaddr();
		logic [31:0] va;
		va = $urandom();
		if (owned_dirs.size() != 0 && $urandom_range(99) < 85) begin
			va[31:22] = owned_dirs[$urandom_range(owned_dirs.size() - 1)];
			if ($urandom_range(99) < 75)
				va[21:12] = 10'($urandom_range(7));
		end
		return va;
	endfunction

	// map into a fresh table, then a hit and a miss on that new table
	task automatic test_fresh_table();
		send_request(ACT_MAP, 32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF);
		send_request(ACT_LOOKUP, 32'h0000_0FFF, 32'h0, 12'h0);
		send_request(ACT_LOOKUP, 32'h003F_F000, 32'hFFFF_FFFF, 12'hFFF);
	endtask

	// unmap of a live entry, of a zero entry, and with no table behind it
	task automatic test_unmap_cases();
		send_request(ACT_UNMAP, 32'h0000_0000, 32'h0, 12'h0);
		send_request(ACT_LOOKUP, 32'h0000_0000, 32'h0, 12'h0);
		send_request(ACT_UNMAP, 32'h0000_0000, 32'h0, 12'h0);
		send_request(ACT_UNMAP, 32'h8000_0000, 32'h0, 12'h0);
		send_request(ACT_LOOKUP, 32'h8000_0123, 32'h0, 12'h0);
	endtask

	// all-ones address with an all-zero entry, which then reads as not mapped
	task automatic test_zero_entry();
		send_request(ACT_MAP, 32'hFFFF_FFFF, 32'h0000_0FFF, 12'h000);
		send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0, 12'h0);
	endtask

	task automatic test_reserved_action();
		send_request(ACT_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 12'hFFF);
	endtask

	// use up the pool on fresh directory entries, then one map too many
	task automatic test_pool_exhaustion();
		logic [31:0] va;
		do begin
			do
				va = $urandom();
			while (page_dir[va[31:22]] != 0);
			send_request(ACT_MAP, va, $urandom(), 12'($urandom()));
		end while (tables_used < POOL_SIZE);
		do
			va = $urandom();
		while (page_dir[va[31:22]] != 0);
		send_request(ACT_MAP, va, $urandom(), 12'($urandom()));
	endtask

	task automatic test_random_traffic(input int unsigned n_items,
			input int unsigned sender_idle, input int unsigned receiver_idle);
		logic [ACT_W-1:0] act;
		logic [31:0]      pa;
		logic [11:0]      flags;
		int unsigned      roll;
		send_idle_pct = sender_idle;
		recv_idle_pct = receiver_idle;
		for (int i = 0; i < n_items; i++) begin
			roll = $urandom_range(99);
			if (roll < 35)
				act = ACT_MAP;
			else if (roll < 55)
				act = ACT_UNMAP;
			else if (roll < 95)
				act = ACT_LOOKUP;
			else
				act = ACT_RSVD;
			pa    = $urandom();
			flags = 12'($urandom());
			// now and then an entry that comes out as zero
			if ($urandom_range(49) == 0) begin
				pa[31:12] = '0;
				flags     = '0;
			end
			send_request(act, pick_vaddr(), pa, flags);
			if (i == n_items / 2)
				wait_for_drain();
		end
	endtask

	// receiver: random back-pressure and the in-order result check
	always @(posedge clk) begin
		page_result_t got;
		page_result_t want;
		got = {m_tuser, m_tdata[31:0], m_tdata[32], m_tdata[52:33]};
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result item with nothing expected, got %h", $time, got);
				failed = 1'b1;
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d got %0d", $time, want.status,
						got.status);
					failed = 1'b1;
				end
				if (got.mapped_addr !== want.mapped_addr) begin
					$display("%0t: mapped_addr expected %h got %h", $time,
						want.mapped_addr, got.mapped_addr);
					failed = 1'b1;
				end
				if (got.tlb_inv !== want.tlb_inv) begin
					$display("%0t: tlb_invalidate expected %0d got %0d", $time,
						want.tlb_inv, got.tlb_inv);
					failed = 1'b1;
				end
				if (got.inv_page !== want.inv_page) begin
					$display("%0t: invalidate_page expected %h got %h", $time,
						want.inv_page, got.inv_page);
					failed = 1'b1;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// run limit, well above the clearing pass plus all items at full stall
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_CAP) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < DIR_DEPTH; i++)
			page_dir[i] = 0;
		for (int i = 0; i < POOL_SIZE * TBL_DEPTH; i++)
			pte_store[i] = '0;
		tables_used = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed items, first idling mix
		test_fresh_table();
		test_unmap_cases();
		test_zero_entry();
		test_reserved_action();
		test_pool_exhaustion();

		// random items: slow receiver, then slow sender, then full rate
		test_random_traffic(608, 27, 82);
		test_random_traffic(608, 82, 27);
		test_random_traffic(608, 0, 0);

		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (failed || expected_results.size() != 0)
			$display("tb: failure");
		else
			$display("tb: success");
		$finish;
	end

endmodule
